// ----- rtl/mwm_pkg.sv -----
// Mecanum wheel mixer package: wheel order, routing masks, compensation
// factors and the divider step shared by the mixer datapath.
// No dependencies.
package mwm_pkg;

  localparam int unsigned NumWheels = 4;
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned NumGroups = 3;

  // Wheel slots
  localparam int unsigned WheelRf = 0;
  localparam int unsigned WheelLf = 1;
  localparam int unsigned WheelRr = 2;
  localparam int unsigned WheelLr = 3;

  // Axis slots
  localparam int unsigned AxisX = 0;  // strafe
  localparam int unsigned AxisY = 1;  // forward
  localparam int unsigned AxisS = 2;  // rotate

  localparam logic [7:0] Center = 8'd127;

  // Per-wheel mirror masks (bit = wheel slot); forward is direct everywhere
  localparam logic [NumWheels-1:0] MirrorX = 4'b1001;  // RF, LR
  localparam logic [NumWheels-1:0] MirrorS = 4'b0101;  // RF, RR

  // Stopped when the summed distance is at or below this
  localparam logic [8:0] DenMin = 9'd12;

  // Compensation factors in twentieths; unity leaves a byte unchanged
  typedef logic [4:0] kfac_t;
  localparam kfac_t KUnity = 5'd20;
  localparam kfac_t K16    = 5'd16;
  localparam kfac_t K22    = 5'd22;
  localparam kfac_t K24    = 5'd24;
  localparam kfac_t K26    = 5'd26;
  localparam kfac_t K27    = 5'd27;
  localparam kfac_t K29    = 5'd29;

  localparam logic [12:0] CompOffset = 13'd2540;
  // floor(v/20) == (v*Recip20) >> 16 for v < 16384
  localparam logic [11:0] Recip20    = 12'd3277;

  // Divider: 8 quotient bits, two per stage
  localparam int unsigned QuoBits     = 8;
  localparam int unsigned BitsPerStep = 2;
  localparam int unsigned DivStages   = QuoBits / BitsPerStep;

  typedef enum logic {
    RegDeadband = 1'b0,
    RegCompEn   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] rem;
    logic        qbit;
  } div_bit_t;

  // One restoring step: subtract den << sh when it fits
  function automatic div_bit_t div_bit(input logic [15:0] rem, input logic [8:0] den,
                                       input logic [2:0] sh);
    logic [16:0] trial;
    div_bit_t    res;
    trial = {1'b0, rem} - ({8'd0, den} << sh);
    if (!trial[16]) begin
      res.rem  = trial[15:0];
      res.qbit = 1'b1;
    end else begin
      res.rem  = rem;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

// ----- rtl/mecanum_wheel_mixer.sv -----
// Mecanum wheel mixer top level: 14-stage pipeline from joystick bytes to
// wheel drive bytes, plus the APB configuration registers. Uses mwm_pkg.
//
// Takes one joystick sample per clock unless an output stall has backed up
// into stage 0. Most of the depth comes from the shared-denominator divider
// (four stages, two quotient bits each) and the three compensation steps (a
// multiply stage and a reciprocal divide-by-20 stage each). Every stage holds
// its own valid bit and a stall backs up only into occupied stages, so
// bubbles are squeezed out.
// Registers: deadband at byte address 0, compensation enable at address 4.
module mecanum_wheel_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // joystick sample
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  strafe_axis_i,
  input  logic [7:0]  forward_axis_i,
  input  logic [7:0]  rotate_axis_i,
  // wheel drive
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  right_front_drive_o,
  output logic [7:0]  left_front_drive_o,
  output logic [7:0]  right_rear_drive_o,
  output logic [7:0]  left_rear_drive_o
);
  import mwm_pkg::*;

  localparam int unsigned DivFirst = 3;
  localparam int unsigned WStage   = DivFirst + DivStages;
  localparam int unsigned NumStages = WStage + 1 + 2 * NumGroups;

  // ---------------- configuration ----------------
  logic [6:0] deadband_q;
  logic       comp_en_q;
  reg_idx_e   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= 7'd10;
      comp_en_q  <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        RegDeadband: deadband_q <= pwdata[6:0];
        RegCompEn:   comp_en_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegDeadband: prdata = {25'd0, deadband_q};
      RegCompEn:   prdata = {31'd0, comp_en_q};
      default:     prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // ---------------- stage 0: distances, targets, factors ----------------
  logic [7:0]        axis    [NumAxes];
  logic [7:0]        ax_dist [NumAxes];
  logic              act     [NumAxes];
  logic signed [8:0] direct  [NumAxes];
  logic signed [8:0] mirror  [NumAxes];
  logic signed [8:0] dev_d   [NumWheels][NumAxes];
  logic [8:0]        den_d;
  logic              stop_d;
  kfac_t             kf_d    [NumGroups][NumWheels];

  assign axis[AxisX] = strafe_axis_i;
  assign axis[AxisY] = forward_axis_i;
  assign axis[AxisS] = rotate_axis_i;

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      ax_dist[a] = (axis[a] >= Center) ? axis[a] - Center : Center - axis[a];
      act[a]     = ax_dist[a] > {1'b0, deadband_q};
      direct[a]  = $signed({1'b0, axis[a]}) - 9'sd127;
      mirror[a]  = 9'sd128 - $signed({1'b0, axis[a]});
    end
    for (int w = 0; w < NumWheels; w++) begin
      dev_d[w][AxisX] = !act[AxisX] ? 9'sd0 : (MirrorX[w] ? mirror[AxisX] : direct[AxisX]);
      dev_d[w][AxisY] = !act[AxisY] ? 9'sd0 : direct[AxisY];
      dev_d[w][AxisS] = !act[AxisS] ? 9'sd0 : (MirrorS[w] ? mirror[AxisS] : direct[AxisS]);
    end
    den_d  = {1'b0, ax_dist[AxisX]} + {1'b0, ax_dist[AxisY]} + {1'b0, ax_dist[AxisS]};
    stop_d = (den_d <= DenMin) || !(act[AxisX] || act[AxisY] || act[AxisS]);
  end

  // Compensation factor selection, one factor per group and wheel
  always_comb begin
    logic cx, cy, cs;
    cx = !act[AxisX];
    cy = !act[AxisY];
    cs = !act[AxisS];
    for (int g = 0; g < NumGroups; g++) begin
      for (int w = 0; w < NumWheels; w++) kf_d[g][w] = KUnity;
    end
    if (comp_en_q) begin
      // forward group
      if (cx && cs) begin
        priority if (forward_axis_i > 8'd175) begin
          kf_d[0][WheelLf] = K22; kf_d[0][WheelLr] = K22;
        end else if (forward_axis_i < 8'd87) begin
          kf_d[0][WheelRf] = K22; kf_d[0][WheelRr] = K22;
        end else if (forward_axis_i > 8'd137) begin
          kf_d[0][WheelLf] = K29; kf_d[0][WheelLr] = K29;
        end else if (forward_axis_i < 8'd117) begin
          kf_d[0][WheelRf] = K27; kf_d[0][WheelRr] = K27;
        end else begin
          // near centre: keep unity
        end
      end
      // rotate group
      if (cx && cy) begin
        priority if (rotate_axis_i < 8'd170 && rotate_axis_i > 8'd137) begin
          kf_d[1][WheelLf] = K27; kf_d[1][WheelLr] = K27;
        end else if (rotate_axis_i > 8'd84 && rotate_axis_i < 8'd117) begin
          kf_d[1][WheelRf] = K26; kf_d[1][WheelRr] = K26;
        end else begin
          // outside both bands: keep unity
        end
      end
      // strafe group
      if (cs && cy) begin
        priority if (strafe_axis_i < 8'd117 && strafe_axis_i > 8'd54) begin
          kf_d[2][WheelLr] = K24; kf_d[2][WheelRr] = K24;
          kf_d[2][WheelLf] = K16; kf_d[2][WheelRf] = K16;
        end else if (strafe_axis_i > 8'd137 && strafe_axis_i < 8'd200) begin
          kf_d[2][WheelLf] = K24; kf_d[2][WheelRf] = K27;
          kf_d[2][WheelLr] = K22; kf_d[2][WheelRr] = K22;
        end else begin
          // outside both bands: keep unity
        end
      end
    end
  end

  // Factors travel with the item through every stage; the stop flag and the denominator go as far as the mixing stage
  kfac_t      kf_q   [NumStages][NumGroups][NumWheels];
  logic       stop_q [WStage];
  logic [8:0] den_q  [WStage];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      kf_q[0]   <= kf_d;
      stop_q[0] <= stop_d;
      den_q[0]  <= den_d;
    end
    for (int i = 1; i < NumStages; i++) begin
      if (en[i]) kf_q[i] <= kf_q[i-1];
    end
    for (int i = 1; i < WStage; i++) begin
      if (en[i]) begin
        stop_q[i] <= stop_q[i-1];
        den_q[i]  <= den_q[i-1];
      end
    end
  end

  logic signed [8:0] dev0_q  [NumWheels][NumAxes];
  logic [7:0]        dist0_q [NumAxes];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dev0_q  <= dev_d;
      dist0_q <= ax_dist;
    end
  end

  // ---------------- stage 1: weighted products ----------------
  logic signed [16:0] prod1_q [NumWheels][NumAxes];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int w = 0; w < NumWheels; w++) begin
        for (int a = 0; a < NumAxes; a++) begin
          prod1_q[w][a] <= 17'(dev0_q[w][a] * $signed({1'b0, dist0_q[a]}));
        end
      end
    end
  end

  // ---------------- stage 2: sum, sign and magnitude ----------------
  logic [15:0] mag2_q [NumWheels];
  logic        neg2_q [NumWheels];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int w = 0; w < NumWheels; w++) begin
        logic signed [17:0] sum;
        sum = 18'(prod1_q[w][0]) + 18'(prod1_q[w][1]) + 18'(prod1_q[w][2]);
        neg2_q[w] <= sum[17];
        mag2_q[w] <= sum[17] ? 16'(-sum) : sum[15:0];
      end
    end
  end

  // ---------------- stages 3..6: divider, two bits per stage ----------------
  logic [15:0]        rem_q [DivStages][NumWheels];
  logic [QuoBits-1:0] quo_q [DivStages][NumWheels];
  logic               neg_q [DivStages][NumWheels];

  for (genvar j = 0; j < DivStages; j++) begin : g_div
    localparam logic [2:0] ShHi = 3'(QuoBits - 1 - BitsPerStep * j);
    always_ff @(posedge clk_i) begin
      if (en[DivFirst+j]) begin
        for (int w = 0; w < NumWheels; w++) begin
          logic [15:0]        r;
          logic [QuoBits-1:0] q;
          div_bit_t           s0, s1;
          r = (j == 0) ? mag2_q[w] : rem_q[(j == 0) ? 0 : j-1][w];
          q = (j == 0) ? '0 : quo_q[(j == 0) ? 0 : j-1][w];
          s0 = div_bit(r, den_q[DivFirst+j-1], ShHi);
          s1 = div_bit(s0.rem, den_q[DivFirst+j-1], ShHi - 3'd1);
          rem_q[j][w] <= s1.rem;
          quo_q[j][w] <= {q[QuoBits-3:0], s0.qbit, s1.qbit};
          neg_q[j][w] <= (j == 0) ? neg2_q[w] : neg_q[(j == 0) ? 0 : j-1][w];
        end
      end
    end
  end

  // ---------------- stage 7: mixed wheel bytes ----------------
  logic [7:0] w7_q [NumWheels];

  always_ff @(posedge clk_i) begin
    if (en[WStage]) begin
      for (int w = 0; w < NumWheels; w++) begin
        logic [8:0] q9;
        q9 = {1'b0, quo_q[DivStages-1][w]};
        if (stop_q[WStage-1]) w7_q[w] <= Center;
        else if (neg_q[DivStages-1][w]) w7_q[w] <= 8'({1'b0, Center} - q9);
        else w7_q[w] <= 8'({1'b0, Center} + q9);
      end
    end
  end

  // ---------------- stages 8..13: compensation steps ----------------
  logic [12:0] cm_q [NumGroups][NumWheels];
  logic [7:0]  cw_q [NumGroups][NumWheels];

  for (genvar g = 0; g < NumGroups; g++) begin : g_comp
    localparam int unsigned MulSt = WStage + 1 + 2 * g;
    always_ff @(posedge clk_i) begin
      if (en[MulSt]) begin
        for (int w = 0; w < NumWheels; w++) begin
          logic [7:0]         m;
          logic signed [15:0] v;
          m = (g == 0) ? w7_q[w] : cw_q[(g == 0) ? 0 : g-1][w];
          v = 16'(($signed({2'b0, m}) - 10'sd127) * $signed({1'b0, kf_q[MulSt-1][g][w]}))
              + $signed({3'b0, CompOffset});
          cm_q[g][w] <= v[15] ? 13'd0 : v[12:0];
        end
      end
      if (en[MulSt+1]) begin
        for (int w = 0; w < NumWheels; w++) begin
          logic [24:0] p;
          p = 25'(cm_q[g][w] * Recip20);
          cw_q[g][w] <= p[24] ? 8'd255 : p[23:16];
        end
      end
    end
  end

  assign right_front_drive_o = cw_q[NumGroups-1][WheelRf];
  assign left_front_drive_o  = cw_q[NumGroups-1][WheelLf];
  assign right_rear_drive_o  = cw_q[NumGroups-1][WheelRr];
  assign left_rear_drive_o   = cw_q[NumGroups-1][WheelLr];

endmodule
